@@ sv/magma_pkg.sv @@
`default_nettype none
package magma_pkg;

  localparam int ROUNDS_DEF = 32;
  localparam int ROT_BITS   = 11;
  localparam int HALF_W     = 32;
  localparam int BLK_W      = 64;
  localparam int NKEY       = 8;
  localparam int KEY_IDX_W  = 4;
  localparam int KEY_SEL_W  = 3;

  localparam logic [3:0] SBOX [0:7][0:15] = '{
    '{4'd12, 4'd4, 4'd6, 4'd2, 4'd10, 4'd5, 4'd11, 4'd9,
      4'd14, 4'd8, 4'd13, 4'd7, 4'd0, 4'd3, 4'd15, 4'd1},
    '{4'd6, 4'd8, 4'd2, 4'd3, 4'd9, 4'd10, 4'd5, 4'd12,
      4'd1, 4'd14, 4'd4, 4'd7, 4'd11, 4'd13, 4'd0, 4'd15},
    '{4'd11, 4'd3, 4'd5, 4'd8, 4'd2, 4'd15, 4'd10, 4'd13,
      4'd14, 4'd1, 4'd7, 4'd4, 4'd12, 4'd9, 4'd6, 4'd0},
    '{4'd12, 4'd8, 4'd2, 4'd1, 4'd13, 4'd4, 4'd15, 4'd6,
      4'd7, 4'd0, 4'd10, 4'd5, 4'd3, 4'd14, 4'd9, 4'd11},
    '{4'd7, 4'd15, 4'd5, 4'd10, 4'd8, 4'd1, 4'd6, 4'd13,
      4'd0, 4'd9, 4'd3, 4'd14, 4'd11, 4'd4, 4'd2, 4'd12},
    '{4'd5, 4'd13, 4'd15, 4'd6, 4'd9, 4'd2, 4'd12, 4'd10,
      4'd11, 4'd7, 4'd8, 4'd1, 4'd4, 4'd3, 4'd14, 4'd0},
    '{4'd8, 4'd14, 4'd2, 4'd5, 4'd6, 4'd9, 4'd1, 4'd12,
      4'd15, 4'd4, 4'd11, 4'd0, 4'd13, 4'd10, 4'd3, 4'd7},
    '{4'd1, 4'd7, 4'd14, 4'd13, 4'd0, 4'd5, 4'd8, 4'd3,
      4'd4, 4'd15, 4'd10, 4'd6, 4'd9, 4'd12, 4'd11, 4'd2}
  };

  typedef struct packed {
    logic vld;
    logic dec;
  } magma_ctl_t;

  function automatic logic [HALF_W-1:0] subst(input logic [HALF_W-1:0] v);
    logic [HALF_W-1:0] r;
    r = '0;
    for (int n = 0; n < 8; n++) begin
      r[4*n +: 4] = SBOX[n][v[4*n +: 4]];
    end
    return r;
  endfunction

  function automatic logic [HALF_W-1:0] round_f(input logic [HALF_W-1:0] k,
                                                input logic [HALF_W-1:0] x);
    logic [HALF_W-1:0] s;
    s = subst(x + k);
    return {s[HALF_W-ROT_BITS-1:0], s[HALF_W-1:HALF_W-ROT_BITS]};
  endfunction

endpackage
`default_nettype wire

@@ sv/magma_round.sv @@
`default_nettype none
module magma_round
  import magma_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire magma_ctl_t        up_ctl,
  input  wire logic [BLK_W-1:0]  up_blk,
  input  wire logic [HALF_W-1:0] up_key,
  output logic                   up_rdy,
  output magma_ctl_t             dn_ctl,
  output logic [BLK_W-1:0]       dn_blk,
  input  wire logic              dn_rdy
);

  logic             vld_r;
  logic             dec_r;
  logic [BLK_W-1:0] blk_r;
  logic [BLK_W-1:0] blk_nxt;

  // blk: {left, right}; new left = old right, new right = left ^ f(right)
  always_comb begin
    blk_nxt = {up_blk[HALF_W-1:0],
               up_blk[BLK_W-1:HALF_W] ^ round_f(up_key, up_blk[HALF_W-1:0])};
  end

  assign up_rdy = !vld_r || dn_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy && up_ctl.vld) begin
      blk_r <= blk_nxt;
      dec_r <= up_ctl.dec;
    end
  end

  assign dn_ctl = '{vld: vld_r, dec: dec_r};
  assign dn_blk = blk_r;

`ifndef SYNTH
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && !dn_rdy |=> vld_r && $stable(blk_r))
    else $error("stalled stage lost or changed its request");
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    up_ctl.vld && up_rdy |=> vld_r)
    else $error("accepted request not captured");
`endif

endmodule
`default_nettype wire

@@ sv/magma_block_cipher_unit.sv @@
`default_nettype none
// One register stage per Feistel round (32 at the default) between input
// accept and result valid.
// Throughput: one block per cycle; each round stage stalls only when it
// holds a request and the next stage is full.
// Reset (rst_n, synchronous, active low) clears the key registers and all
// stage valid bits.
module magma_block_cipher_unit
  import magma_pkg::*;
#(
  parameter int ROUNDS = ROUNDS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [BLK_W-1:0]     in_tdata,   // [63:0] data_block
  input  wire logic                 in_tuser,   // [0] req_type
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [BLK_W-1:0]          out_tdata,  // [63:0] result_block
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [KEY_IDX_W-1:0] cfg_index,
  input  wire logic [HALF_W-1:0]    cfg_data
);

  localparam int NSTG = (ROUNDS / 8) * 8;

  logic [HALF_W-1:0] key_r [0:NKEY-1];

  magma_ctl_t        ctl [0:NSTG];
  logic [BLK_W-1:0]  blk [0:NSTG];
  logic [NSTG:0]     rdy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NKEY; i++) begin
        key_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_index < KEY_IDX_W'(NKEY)) begin
      key_r[cfg_index[KEY_SEL_W-1:0]] <= cfg_data;
    end
  end

  assign ctl[0]    = '{vld: in_tvalid, dec: in_tuser};
  assign blk[0]    = in_tdata;
  assign in_tready = rdy[0];
  assign rdy[NSTG] = out_tready;

  for (genvar s = 0; s < NSTG; s++) begin : g_rnd
    localparam int GRP = s / 8;
    localparam int POS = s % 8;
    logic              rev;
    logic [HALF_W-1:0] key;

    // encrypt: reversed key order in group 3; decrypt: after group 0
    assign rev = ctl[s].dec ? (GRP != 0) : (GRP == 3);
    assign key = rev ? key_r[NKEY-1-POS] : key_r[POS];

    magma_round u_rnd (
      .clk    (clk),
      .rst_n  (rst_n),
      .up_ctl (ctl[s]),
      .up_blk (blk[s]),
      .up_key (key),
      .up_rdy (rdy[s]),
      .dn_ctl (ctl[s+1]),
      .dn_blk (blk[s+1]),
      .dn_rdy (rdy[s+1])
    );
  end

  // last swap undone
  assign out_tvalid = ctl[NSTG].vld;
  assign out_tdata  = {blk[NSTG][HALF_W-1:0], blk[NSTG][BLK_W-1:HALF_W]};

`ifndef SYNTH
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped under backpressure");
  a_key_wr: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_index == KEY_IDX_W'(0) |=> key_r[0] == $past(cfg_data))
    else $error("key word 0 write lost");
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    ctl[1].vld && !rdy[1] |-> !in_tready)
    else $error("input accepted into a full first stage");
`endif

endmodule
`default_nettype wire
